// ===== design/pdi_pkg.sv =====
package pdi_pkg;

  localparam int COORD_W         = 24;
  localparam int DIST_W          = 24;
  localparam int FRAC_W          = 16;
  localparam int ENTRY_W         = 4;
  localparam int SEG_W           = 4;
  localparam int POINT_COUNT_DEF = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // datapath operation for the current cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_WRITE,
    DP_READ,
    DP_LATCH_TO,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_MUL_X,
    DP_MUL_Y,
    DP_RND_Y
  } dp_op_t;

  // source of the result register
  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_DIRECT,
    OUT_BLEND
  } out_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic gt;
  } dp_status_t;

endpackage

// ===== design/pdi_dpath.sv =====
module pdi_dpath #(
  parameter int POINT_COUNT = pdi_pkg::POINT_COUNT_DEF,
  parameter int IDX_W       = $clog2(POINT_COUNT)
) (
  input  logic                                clk,
  input  pdi_pkg::dp_cmd_t                    cmd,
  input  logic [IDX_W-1:0]                    rd_addr,
  input  logic [IDX_W-1:0]                    seg,
  output pdi_pkg::dp_status_t                 status,
  input  logic [pdi_pkg::ENTRY_W-1:0]         in_entry_index,
  input  logic signed [pdi_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [pdi_pkg::COORD_W-1:0]  in_point_y,
  input  logic [pdi_pkg::DIST_W-1:0]          in_point_distance,
  input  logic [pdi_pkg::DIST_W-1:0]          in_query_distance,
  output logic signed [pdi_pkg::COORD_W-1:0]  out_x,
  output logic signed [pdi_pkg::COORD_W-1:0]  out_y,
  output logic [pdi_pkg::SEG_W-1:0]           out_segment,
  output logic                                out_done_res
);

  localparam int CW      = pdi_pkg::COORD_W;
  localparam int DW      = pdi_pkg::DIST_W;
  localparam int FW      = pdi_pkg::FRAC_W;
  localparam int EW      = pdi_pkg::ENTRY_W;
  localparam int SEG_W_L = pdi_pkg::SEG_W;
  localparam int WORD_W  = 2 * CW + DW;
  localparam int DIFF_W  = CW + 1;
  localparam int PROD_W  = DIFF_W + FW + 1;
  localparam int CHK_W   = IDX_W + EW;

  // captured item
  logic [EW-1:0]        idx_r;
  logic [CW-1:0]        px_r, py_r;
  logic [DW-1:0]        pd_r, q_r;

  // point table: x, y, distance packed in one word
  logic [WORD_W-1:0]    mem [POINT_COUNT];
  logic [WORD_W-1:0]    rd_word_r;
  logic [DW-1:0]        last_d_r;

  logic [CW-1:0]        rd_x, rd_y;
  logic [DW-1:0]        rd_d;

  logic [CW-1:0]        to_x_r, to_y_r, from_x_r, from_y_r;
  logic [DW-1:0]        to_d_r, span_r, rem_r;
  logic [FW-1:0]        f_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [CW-1:0]        res_x_r, res_y_r;

  logic [CW-1:0]        out_x_r, out_y_r;
  logic [SEG_W_L-1:0]   out_seg_r;
  logic                 out_done_r;

  logic [CHK_W-1:0]     wr_idx_ext;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_in_range;
  logic [IDX_W+SEG_W_L-1:0] seg_ext;
  logic [DW:0]          rem2, rem_sub;
  logic                 rem_ge;
  logic signed [PROD_W-1:0] mul_a;
  logic signed [FW:0]   f_s;

  assign wr_idx_ext  = {{IDX_W{1'b0}}, idx_r};
  assign wr_addr     = wr_idx_ext[IDX_W-1:0];
  assign wr_in_range = wr_idx_ext < CHK_W'(POINT_COUNT);
  assign seg_ext     = {{SEG_W_L{1'b0}}, seg};

  assign rd_x = rd_word_r[WORD_W-1 -: CW];
  assign rd_y = rd_word_r[DW+CW-1 -: CW];
  assign rd_d = rd_word_r[DW-1:0];

  assign status.gt = rd_d > q_r;

  // one restoring divide step
  assign rem2    = {rem_r, 1'b0};
  assign rem_sub = rem2 - {1'b0, span_r};
  assign rem_ge  = rem2 >= {1'b0, span_r};

  assign f_s = $signed({1'b0, f_r});

  // from + round_half_up(prod / 2^FW)
  function automatic logic [CW-1:0] round_add(input logic [CW-1:0] from,
                                               input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [PROD_W-1:0] r;
    s = p + (PROD_W'(1) <<< (FW - 1));
    r = (s >>> FW) + PROD_W'($signed(from));
    return r[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.op == pdi_pkg::DP_WRITE && wr_in_range) begin
      mem[wr_addr] <= {px_r, py_r, pd_r};
    end
    if (cmd.op == pdi_pkg::DP_READ) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pdi_pkg::DP_NOP: begin
      end
      pdi_pkg::DP_CAPTURE: begin
        idx_r <= in_entry_index;
        px_r  <= in_point_x;
        py_r  <= in_point_y;
        pd_r  <= in_point_distance;
        q_r   <= in_query_distance;
      end
      pdi_pkg::DP_WRITE: begin
        if (wr_in_range && wr_addr == IDX_W'(POINT_COUNT - 1)) begin
          last_d_r <= pd_r;
        end
      end
      pdi_pkg::DP_READ: begin
      end
      pdi_pkg::DP_LATCH_TO: begin
        to_x_r <= rd_x;
        to_y_r <= rd_y;
        to_d_r <= rd_d;
      end
      pdi_pkg::DP_DIV_INIT: begin
        span_r   <= to_d_r - rd_d;
        rem_r    <= q_r - rd_d;
        dx_r     <= DIFF_W'($signed(to_x_r)) - DIFF_W'($signed(rd_x));
        dy_r     <= DIFF_W'($signed(to_y_r)) - DIFF_W'($signed(rd_y));
        from_x_r <= rd_x;
        from_y_r <= rd_y;
        f_r      <= '0;
      end
      pdi_pkg::DP_DIV_STEP: begin
        rem_r <= rem_ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
        f_r   <= {f_r[FW-2:0], rem_ge};
      end
      pdi_pkg::DP_MUL_X: begin
        prod_r <= mul_a;
      end
      pdi_pkg::DP_MUL_Y: begin
        res_x_r <= round_add(from_x_r, prod_r);
        prod_r  <= mul_a;
      end
      pdi_pkg::DP_RND_Y: begin
        res_y_r <= round_add(from_y_r, prod_r);
      end
      default: begin
      end
    endcase
  end

  // single shared multiplier, x then y
  assign mul_a = (cmd.op == pdi_pkg::DP_MUL_X) ? PROD_W'(dx_r) * PROD_W'(f_s)
                                               : PROD_W'(dy_r) * PROD_W'(f_s);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        pdi_pkg::OUT_DIRECT: begin
          out_x_r <= rd_x;
          out_y_r <= rd_y;
        end
        pdi_pkg::OUT_BLEND: begin
          out_x_r <= res_x_r;
          out_y_r <= res_y_r;
        end
        default: begin
          out_x_r <= '0;
          out_y_r <= '0;
        end
      endcase
      out_seg_r  <= seg_ext[SEG_W_L-1:0];
      out_done_r <= (cmd.out_sel != pdi_pkg::OUT_ZERO) && (q_r >= last_d_r);
    end
  end

  assign out_x        = out_x_r;
  assign out_y        = out_y_r;
  assign out_segment  = out_seg_r;
  assign out_done_res = out_done_r;

endmodule

// ===== design/pdi_ctrl.sv =====
module pdi_ctrl #(
  parameter int POINT_COUNT = pdi_pkg::POINT_COUNT_DEF,
  parameter int IDX_W       = $clog2(POINT_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pdi_pkg::dp_status_t status,
  output pdi_pkg::dp_cmd_t    cmd,
  output logic [IDX_W-1:0]    rd_addr,
  output logic [IDX_W-1:0]    seg
);

  localparam int CNT_W = $clog2(pdi_pkg::FRAC_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_READ_FROM,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL_X,
    ST_MUL_Y,
    ST_RND_Y,
    ST_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    seg_r, seg_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  pdi_pkg::out_sel_t   sel_r, sel_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    seg_nxt      = seg_r;
    cnt_nxt      = cnt_r;
    sel_nxt      = sel_r;
    cmd.op       = pdi_pkg::DP_NOP;
    cmd.out_load = 1'b0;
    cmd.out_sel  = sel_r;
    rd_addr      = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = pdi_pkg::DP_CAPTURE;
          idx_nxt   = '0;
          seg_nxt   = '0;
          state_nxt = (in_opcode == pdi_pkg::OP_WRITE) ? ST_WRITE : ST_SRCH_RD;
        end
      end
      ST_WRITE: begin
        cmd.op    = pdi_pkg::DP_WRITE;
        sel_nxt   = pdi_pkg::OUT_ZERO;
        state_nxt = ST_OUT;
      end
      ST_SRCH_RD: begin
        cmd.op    = pdi_pkg::DP_READ;
        state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (status.gt) begin
          if (idx_r == '0) begin
            sel_nxt   = pdi_pkg::OUT_DIRECT;
            seg_nxt   = '0;
            state_nxt = ST_OUT;
          end else begin
            cmd.op    = pdi_pkg::DP_LATCH_TO;
            seg_nxt   = idx_r - 1'b1;
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_READ_FROM;
          end
        end else if (idx_r == IDX_W'(POINT_COUNT - 1)) begin
          sel_nxt   = pdi_pkg::OUT_DIRECT;
          seg_nxt   = IDX_W'(POINT_COUNT - 2);
          state_nxt = ST_OUT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_READ_FROM: begin
        cmd.op    = pdi_pkg::DP_READ;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op    = pdi_pkg::DP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = pdi_pkg::DP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pdi_pkg::FRAC_W - 1)) begin
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.op    = pdi_pkg::DP_MUL_X;
        state_nxt = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.op    = pdi_pkg::DP_MUL_Y;
        state_nxt = ST_RND_Y;
      end
      ST_RND_Y: begin
        cmd.op    = pdi_pkg::DP_RND_Y;
        sel_nxt   = pdi_pkg::OUT_BLEND;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      seg_r       <= '0;
      cnt_r       <= '0;
      sel_r       <= pdi_pkg::OUT_ZERO;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      seg_r       <= seg_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign seg       = seg_r;

endmodule

// ===== design/polyline_distance_interpolator_top.sv =====
// polyline distance interpolator
// holds a table of POINT_COUNT polyline points (x, y, cumulative distance)
// input channel: in_valid / in_stall; one request is either a table write
//   (in_opcode = 0, slot in_entry_index) or a query at in_query_distance
// result channel: out_valid / out_stall; exactly one result per request,
//   zero fields for a write, interpolated point, segment and done for a query
// one request is worked on at a time; in_stall stays high until its result
//   sits in the output register
// a write passes through the write state to the output register
// a query scans the table from entry 0 through the table's read port until
//   an entry's distance exceeds the query or the last entry is read; then a
//   16-step restoring divide and the shared multiplier (x then y) set the rest
// a query below the first point or past the end takes that table point directly
// the next request is accepted in the cycle after a result loads
// a finished result waits in the output register under out_stall while the
//   next request is already accepted; that request then holds before its
//   own result until the register is taken
// reset clears the controller and out_valid; table entries are not cleared
//   and must be written before a query reads them
module polyline_distance_interpolator_top #(
  parameter int POINT_COUNT = pdi_pkg::POINT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_opcode,
  input  logic [pdi_pkg::ENTRY_W-1:0]         in_entry_index,
  input  logic signed [pdi_pkg::COORD_W-1:0]  in_point_x,
  input  logic signed [pdi_pkg::COORD_W-1:0]  in_point_y,
  input  logic [pdi_pkg::DIST_W-1:0]          in_point_distance,
  input  logic [pdi_pkg::DIST_W-1:0]          in_query_distance,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pdi_pkg::COORD_W-1:0]  out_x,
  output logic signed [pdi_pkg::COORD_W-1:0]  out_y,
  output logic [pdi_pkg::SEG_W-1:0]           out_segment,
  output logic                                out_done_res
);

  localparam int IDX_W = $clog2(POINT_COUNT);

  // command and status between controller and datapath
  pdi_pkg::dp_cmd_t    cmd;
  pdi_pkg::dp_status_t status;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    seg;

  // sequencer: table scan, divide steps, multiply steps, result handoff
  pdi_ctrl #(
    .POINT_COUNT (POINT_COUNT),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .seg       (seg)
  );

  // table memory, divider, shared multiplier and output register
  pdi_dpath #(
    .POINT_COUNT (POINT_COUNT),
    .IDX_W       (IDX_W)
  ) u_dpath (
    .clk               (clk),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .seg               (seg),
    .status            (status),
    .in_entry_index    (in_entry_index),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_distance (in_point_distance),
    .in_query_distance (in_query_distance),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_segment       (out_segment),
    .out_done_res      (out_done_res)
  );

endmodule

// ===== design/pdi_checker.sv =====
module pdi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [pdi_pkg::COORD_W-1:0]  out_x,
  input logic signed [pdi_pkg::COORD_W-1:0]  out_y,
  input logic [pdi_pkg::SEG_W-1:0]           out_segment,
  input logic                                out_done_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_segment) && $stable(out_done_res))
    else $error("stalled result changed");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state after reset wrong");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accept");

  // finishing a request always presents its result
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(in_stall) |-> out_valid)
    else $error("request finished without result");

endmodule

bind polyline_distance_interpolator_top pdi_checker u_pdi_checker (.*);

// ===== tb/polyline_distance_interpolator_top_test.sv =====
`timescale 1ns / 100ps

module polyline_distance_interpolator_top_test;
  import pdi_pkg::*;

  localparam int POINTS = POINT_COUNT_DEF;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int IDLE_PCT = 36;
  // allow for the slowest query at sixteen points, leave some margin
  localparam int DRAIN_CYCLES = 80;
  localparam int REPORT_LIMIT = 10;

  // one request as the sender sees it
  typedef struct packed {
    logic                      opcode;
    logic [ENTRY_W-1:0]        entry;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [DIST_W-1:0]         pdist;
    logic [DIST_W-1:0]         qdist;
  } path_request_t;

  // one result as the block should return it
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SEG_W-1:0]          seg;
    logic                      done;
  } point_result_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_opcode = OP_WRITE;
  logic [ENTRY_W-1:0]        in_entry_index = '0;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic [DIST_W-1:0]         in_point_distance = '0;
  logic [DIST_W-1:0]         in_query_distance = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [SEG_W-1:0]          out_segment;
  logic                      out_done_res;

  // mirror of the point table, updated when a write request is accepted
  logic signed [COORD_W-1:0] path_x [POINTS];
  logic signed [COORD_W-1:0] path_y [POINTS];
  logic [DIST_W-1:0]         path_dist [POINTS];

  point_result_t expected_points[$];
  int            mismatch_count = 0;
  // set while both sides run without any idle cycles
  bit            steady_flow = 1'b0;

  polyline_distance_interpolator_top #(
    .POINT_COUNT(POINTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_entry_index   (in_entry_index),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_distance(in_point_distance),
    .in_query_distance(in_query_distance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_segment      (out_segment),
    .out_done_res     (out_done_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // prediction
  // ------------------------------------------------------------------

  // round half up of (from * (1 - f) + to * f), f in Q0.16
  function automatic logic signed [COORD_W-1:0] blend_coord(
    logic signed [COORD_W-1:0] from_pt,
    logic signed [COORD_W-1:0] to_pt,
    logic [FRAC_W-1:0]         frac
  );
    longint fw;
    longint acc;
    longint rounded;
    fw = longint'(frac);
    acc = longint'(from_pt) * (64'sd65536 - fw) + longint'(to_pt) * fw;
    // arithmetic shift gives the floor for negative sums too
    rounded = (acc + 64'sd32768) >>> FRAC_W;
    return rounded[COORD_W-1:0];
  endfunction

  // applies a request to the mirrored table and returns its result
  function automatic point_result_t predict_point(path_request_t r);
    point_result_t res;
    int            hit;
    logic [DIST_W-1:0] base;
    logic [DIST_W-1:0] span;
    logic [63:0]       quot;
    res = '0;
    hit = -1;
    if (r.opcode == OP_WRITE) begin
      path_x[r.entry] = r.px;
      path_y[r.entry] = r.py;
      path_dist[r.entry] = r.pdist;
      return res;
    end
    // first entry whose distance exceeds the query
    for (int i = POINTS - 1; i >= 0; i--) begin
      if (path_dist[i] > r.qdist) hit = i;
    end
    if (hit < 0) begin
      // past the end: last point exactly
      res.seg = SEG_W'(POINTS - 2);
      res.x = path_x[POINTS-1];
      res.y = path_y[POINTS-1];
    end else if (hit == 0) begin
      // below the first point: clamp to point 0
      res.seg = '0;
      res.x = path_x[0];
      res.y = path_y[0];
    end else begin
      base = path_dist[hit-1];
      span = path_dist[hit] - base;
      quot = ({40'd0, r.qdist - base} << FRAC_W) / {40'd0, span};
      if (quot > 64'd65535) quot = 64'd65535;
      res.seg = SEG_W'(hit - 1);
      res.x = blend_coord(path_x[hit-1], path_x[hit], quot[FRAC_W-1:0]);
      res.y = blend_coord(path_y[hit-1], path_y[hit], quot[FRAC_W-1:0]);
    end
    res.done = (r.qdist >= path_dist[POINTS-1]);
    return res;
  endfunction

  // ------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------

  // drives one request, holds it until accepted, then logs its result
  task automatic send_request(input path_request_t r);
    // random idle cycles before the request, none during steady flow
    while (!steady_flow && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= r.opcode;
    in_entry_index    <= r.entry;
    in_point_x        <= r.px;
    in_point_y        <= r.py;
    in_point_distance <= r.pdist;
    in_query_distance <= r.qdist;
    // accepted at the first edge with in_stall low
    do @(posedge clk); while (in_stall);
    expected_points.push_back(predict_point(r));
  endtask

  // write requests carry a random query distance the block must ignore
  function automatic path_request_t make_write(
    logic [ENTRY_W-1:0]        slot,
    logic signed [COORD_W-1:0] x,
    logic signed [COORD_W-1:0] y,
    logic [DIST_W-1:0]         d
  );
    path_request_t r;
    r.opcode = OP_WRITE;
    r.entry = slot;
    r.px = x;
    r.py = y;
    r.pdist = d;
    r.qdist = DIST_W'($urandom());
    return r;
  endfunction

  // query requests carry random write fields the block must ignore
  function automatic path_request_t make_query(logic [DIST_W-1:0] q);
    path_request_t r;
    r.opcode = OP_QUERY;
    r.entry = ENTRY_W'($urandom());
    r.px = COORD_W'($urandom());
    r.py = COORD_W'($urandom());
    r.pdist = DIST_W'($urandom());
    r.qdist = q;
    return r;
  endfunction

  // coordinates lean toward the extremes and toward small values
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(7, 0))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      2, 3:    return COORD_W'(int'($urandom_range(2048, 0)) - 1024);
      default: return COORD_W'($urandom());
    endcase
  endfunction

  // query distance aimed at the current table
  function automatic logic [DIST_W-1:0] pick_query();
    int s;
    s = $urandom_range(POINTS - 2, 0);
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4, 5: begin
        // inside a segment
        if (path_dist[s] < path_dist[s+1])
          return DIST_W'($urandom_range(path_dist[s+1] - 1, path_dist[s]));
        return path_dist[s];
      end
      // exactly on a point
      6: return path_dist[$urandom_range(POINTS - 1, 0)];
      // at or past the total distance
      7: return DIST_W'($urandom_range(DIST_MAX, path_dist[POINTS-1]));
      // before the first point
      8: begin
        if (path_dist[0] == '0) return '0;
        return DIST_W'($urandom_range(path_dist[0] - 1, 0));
      end
      default: return DIST_W'($urandom());
    endcase
  endfunction

  // writes all sixteen entries; ordered tables grow by up to step_max per point
  task automatic load_path(input int step_max, input bit ordered, input bit top_down);
    logic [DIST_W-1:0] path_d [POINTS];
    int acc;
    int slot;
    acc = ($urandom_range(3, 0) == 0) ? 0 : int'($urandom_range(step_max, 0));
    for (int i = 0; i < POINTS; i++) begin
      if (ordered) begin
        path_d[i] = (acc > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(acc);
        acc += int'($urandom_range(step_max, 0));
      end else begin
        path_d[i] = DIST_W'($urandom());
      end
    end
    for (int i = 0; i < POINTS; i++) begin
      slot = top_down ? POINTS - 1 - i : i;
      send_request(make_write(ENTRY_W'(slot), pick_coord(), pick_coord(), path_d[slot]));
    end
  endtask

  task automatic run_queries(input int count);
    repeat (count) send_request(make_query(pick_query()));
  endtask

  // ------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------

  // hand-built path: extreme coordinates, a one-unit segment, a zero-length
  // segment and a total at the top of the distance range
  task automatic test_directed_path();
    logic [DIST_W-1:0] d;
    send_request(make_write(ENTRY_W'(0), COORD_MIN, COORD_MAX, 24'h000100));
    send_request(make_write(ENTRY_W'(1), COORD_MAX, COORD_MIN, 24'h000101));
    send_request(make_write(ENTRY_W'(2), COORD_MIN, COORD_MAX, 24'h010101));
    d = 24'h010101;
    for (int i = 3; i < POINTS - 1; i++) begin
      // entry 14 repeats entry 13, so that segment has zero length
      if (i < POINTS - 2) d = d + 24'h012345;
      send_request(make_write(ENTRY_W'(i), pick_coord(), pick_coord(), d));
    end
    send_request(make_write(ENTRY_W'(POINTS - 1), COORD_MAX, COORD_MIN, DIST_MAX));
    // below the first point
    send_request(make_query(24'h000000));
    // exactly on the first point
    send_request(make_query(24'h000100));
    // halfway between opposite extremes
    send_request(make_query(24'h008101));
    // largest fraction between opposite extremes
    send_request(make_query(24'h010100));
    // on the zero-length segment's start
    send_request(make_query(d));
    // just short of the end, then exactly at the end
    send_request(make_query(DIST_MAX - 24'd1));
    send_request(make_query(DIST_MAX));
  endtask

  // well-formed paths of many scales, queried across every segment
  task automatic test_random_paths();
    int step_max;
    for (int n = 0; n < 12; n++) begin
      case (n % 5)
        0:       step_max = 3;
        1:       step_max = 'hFF;
        2:       step_max = 'h3FFF;
        3:       step_max = 'hFFFFF;
        default: step_max = 'h110000;
      endcase
      load_path(step_max, 1'b1, 1'($urandom_range(1, 0)));
      run_queries(60);
    end
  endtask

  // distances in no particular order
  task automatic test_uneven_distances();
    repeat (4) begin
      load_path(0, 1'b0, 1'($urandom_range(1, 0)));
      run_queries(40);
    end
  endtask

  // single entries rewritten between queries
  task automatic test_entry_updates();
    int slot;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    logic [DIST_W-1:0] d;
    load_path('h3FFF, 1'b1, 1'b0);
    repeat (200) begin
      if ($urandom_range(3, 0) == 0) begin
        slot = $urandom_range(POINTS - 1, 0);
        lo = (slot > 0) ? path_dist[slot-1] : '0;
        hi = (slot < POINTS - 1) ? path_dist[slot+1] : DIST_MAX;
        // mostly keep the path in order, sometimes break it
        if ($urandom_range(3, 0) == 0) d = DIST_W'($urandom());
        else d = DIST_W'($urandom_range(hi, lo));
        send_request(make_write(ENTRY_W'(slot), pick_coord(), pick_coord(), d));
      end else begin
        send_request(make_query(pick_query()));
      end
    end
  endtask

  // no idle cycles on either side
  task automatic test_steady_flow();
    steady_flow = 1'b1;
    repeat (2) begin
      load_path('hFFFFF, 1'b1, 1'b0);
      run_queries(50);
    end
    steady_flow = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // result side
  // ------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99, 0) < IDLE_PCT);
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    point_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("unexpected result x=%0d y=%0d seg=%0d done=%0b",
                                out_x, out_y, out_segment, out_done_res));
      end else begin
        want = expected_points.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_segment !== want.seg ||
            out_done_res !== want.done)
          flag_mismatch($sformatf(
            "expected x=%0d y=%0d seg=%0d done=%0b, got x=%0d y=%0d seg=%0d done=%0b",
            want.x, want.y, want.seg, want.done,
            out_x, out_y, out_segment, out_done_res));
      end
    end
  end

  // ------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_path();
    test_random_paths();
    test_uneven_distances();
    test_entry_updates();
    test_steady_flow();
    in_valid <= 1'b0;
    // drain, then give any stray result time to show up
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("polyline_distance_interpolator_top_test OK");
    end else begin
      $display("polyline_distance_interpolator_top_test NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #8000000;
    $display("polyline_distance_interpolator_top_test NOT OK");
    $finish;
  end

endmodule
